### hw/rtl/bst_pkg.sv
// package: sizes, codes, controller state type, cell control struct and encoder function for the set table
`timescale 1ns / 1ps
package bst_pkg;

   localparam int CAPACITY  = 64;
   localparam int IDX_W     = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int VAL_W     = 32;
   localparam int ACT_W     = 2;
   localparam int STAT_W    = 3;
   localparam int POS_W     = 6;
   localparam int CNT_OUT_W = 7;

   localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;

   localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STAT_W-1:0] ST_PRESENT  = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STAT_W-1:0] ST_REMOVED  = 3'd3;
   localparam logic [STAT_W-1:0] ST_ABSENT   = 3'd4;
   localparam logic [STAT_W-1:0] ST_FOUND    = 3'd5;

   typedef enum logic [0:0] {
      FSM_IDLE,
      FSM_RESOLVE
   } fsm_type;

   typedef struct packed {
      logic             match_en;
      logic             ins_en;
      logic             del_en;
      logic [VAL_W-1:0] value;
      logic [IDX_W-1:0] slot;
      logic [CNT_W-1:0] count;
   } bst_ctl_type;

   // entries are distinct, so at most one bit is set and an or of indexes suffices
   function automatic logic [IDX_W-1:0] onehot_to_index(input logic [CAPACITY-1:0] hits);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         idx = idx | (IDX_W'(i) & {IDX_W{hits[i]}});
      end
      return idx;
   endfunction

endpackage

### hw/rtl/bst_cell.sv
// one table slot: holds an entry, compares it, loads an inserted value, takes its upper neighbor on a delete
`timescale 1ns / 1ps
module bst_cell
   import bst_pkg::*;
(
   input  logic             clock,
   input  logic [IDX_W-1:0] index,
   input  bst_ctl_type      ctl,
   input  logic [VAL_W-1:0] next_entry,
   output logic [VAL_W-1:0] entry_ff,
   output logic             match_ff
);

   logic             occupied;
   logic [VAL_W-1:0] entry_in;
   logic             match_in;

   assign occupied = CNT_W'(index) < ctl.count;
   assign match_in = occupied && (entry_ff == ctl.value);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins_en && (CNT_W'(index) == ctl.count)) begin
         entry_in = ctl.value;
      end else if (ctl.del_en && (index >= ctl.slot)) begin
         // later entries slide down one slot
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (ctl.match_en) begin
         match_ff <= match_in;
      end
   end

endmodule

### hw/rtl/bounded_set_table_top.sv
// top level: chain of slot cells, resolve controller and result register
// an accepted request is compared in the slot cells, then resolved into the result register behind rsp_valid
// a new request is taken only in idle, so not before the previous one has been resolved
// a waiting result does not block the next request; resolve holds only on a full output
// reset clears the element count and the controller; slot contents are not cleared
`timescale 1ns / 1ps
module bounded_set_table_top
   import bst_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [ACT_W-1:0]  req_action,
   input  logic signed [VAL_W-1:0] req_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [STAT_W-1:0] rsp_status,
   output logic [POS_W-1:0]  rsp_position,
   output logic [CNT_OUT_W-1:0] rsp_count
);

   fsm_type state_ff, state_in;

   logic [ACT_W-1:0]  action_ff;
   logic [VAL_W-1:0]  value_ff;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]    status_ff;
   logic [POS_W-1:0]     position_ff;
   logic [CNT_OUT_W-1:0] rcount_ff;

   logic accept;
   logic go;

   logic [VAL_W-1:0]  entry [CAPACITY];
   logic [VAL_W-1:0]  next_entry [CAPACITY];
   logic [CAPACITY-1:0] match;

   logic              hit;
   logic [IDX_W-1:0]  slot;
   logic              is_ins, is_del, full;
   logic [STAT_W-1:0] status_val;
   logic [IDX_W-1:0]  pos_val;

   bst_ctl_type ctl;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_valid) state_in = FSM_RESOLVE;
         end
         FSM_RESOLVE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // controller outputs
   always_comb begin
      req_stall = 1'b1;
      go        = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            req_stall = 1'b0;
         end
         FSM_RESOLVE: begin
            go = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign accept = req_valid && !req_stall;

   assign hit    = |match;
   assign slot   = onehot_to_index(match);
   assign is_ins = action_ff == ACT_INSERT;
   assign is_del = action_ff == ACT_DELETE;
   assign full   = count_ff >= CNT_W'(CAPACITY);

   always_comb begin
      status_val = ST_ABSENT;
      pos_val    = '0;
      count_in   = count_ff;
      if (is_ins) begin
         if (hit) begin
            status_val = ST_PRESENT;
            pos_val    = slot;
         end else if (full) begin
            status_val = ST_FULL;
         end else begin
            status_val = ST_INSERTED;
            pos_val    = IDX_W'(count_ff);
            count_in   = count_ff + CNT_W'(1);
         end
      end else if (is_del) begin
         if (hit) begin
            status_val = ST_REMOVED;
            pos_val    = slot;
            count_in   = count_ff - CNT_W'(1);
         end
      end else if (hit) begin
         // lookup, and the unused action code behaves as one
         status_val = ST_FOUND;
         pos_val    = slot;
      end
   end

   always_comb begin
      ctl.match_en = accept;
      ctl.ins_en   = go && is_ins && !hit && !full;
      ctl.del_en   = go && is_del && hit;
      ctl.value    = (state_ff == FSM_IDLE) ? VAL_W'(req_value) : value_ff;
      ctl.slot     = slot;
      ctl.count    = count_ff;
   end

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         if (g == CAPACITY - 1) begin : g_last
            assign next_entry[g] = entry[g];
         end else begin : g_mid
            assign next_entry[g] = entry[g+1];
         end
         bst_cell u_cell (
            .clock      (clock),
            .index      (IDX_W'(g)),
            .ctl        (ctl),
            .next_entry (next_entry[g]),
            .entry_ff   (entry[g]),
            .match_ff   (match[g])
         );
      end
   endgenerate

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (go) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         value_ff  <= VAL_W'(req_value);
      end
      if (go) begin
         status_ff   <= status_val;
         position_ff <= POS_W'(pos_val);
         rcount_ff   <= CNT_OUT_W'(count_in);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_position = position_ff;
   assign rsp_count    = rcount_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count beyond capacity");

   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_RESOLVE) |-> $onehot0(match))
      else $error("more than one slot matches");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      go |=> rsp_valid_ff)
      else $error("resolved transfer did not reach the output register");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (!reset && !go) |=> $stable(count_ff))
      else $error("count changed without a resolved operation");

endmodule

### tb/sv/testbench.sv
// testbench for the bounded set table: queued stimulus, table predictor, result checker
`timescale 1ns / 1ps
module testbench;
   import bst_pkg::*;

   localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;
   localparam logic [ACT_W-1:0] ACT_SPARE  = 2'd3;

   localparam int RESET_CYCLES  = 5;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 20;
   localparam int CALM_START    = 1500;
   localparam int CALM_END      = 3500;
   localparam int POOL_SIZE     = 80;
   localparam int RANDOM_ITEMS  = 1830;
   localparam int PHASE_ITEMS   = 200;
   localparam int DRAIN_EVERY   = 600;

   localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
   localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;

   typedef enum int {
      MIX_GROW,
      MIX_EVEN,
      MIX_SHRINK
   } mix_type;

   typedef struct {
      bit               drain;
      logic [ACT_W-1:0] action;
      logic [VAL_W-1:0] value;
   } set_op_type;

   typedef struct {
      logic [STAT_W-1:0]    status;
      logic [POS_W-1:0]     position;
      logic [CNT_OUT_W-1:0] count;
   } set_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [ACT_W-1:0]        req_action = '0;
   logic signed [VAL_W-1:0] req_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [STAT_W-1:0]       rsp_status;
   logic [POS_W-1:0]        rsp_position;
   logic [CNT_OUT_W-1:0]    rsp_count;

   set_op_type     pending_ops[$];
   set_result_type expected_results[$];

   // predictor state: the set as the block should hold it
   logic [VAL_W-1:0] slots[CAPACITY];
   int               held_count = 0;

   int cycle_count    = 0;
   int n_total        = 0;
   int n_accepted     = 0;
   int n_checked      = 0;
   int mismatch_count = 0;

   logic [VAL_W-1:0] value_pool[POOL_SIZE];

   bounded_set_table_top u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_position (rsp_position),
      .rsp_count    (rsp_count)
   );

   always #5 clock = ~clock;

   function automatic bit roll_idle();
      if (cycle_count >= CALM_START && cycle_count < CALM_END) begin
         return 1'b0;
      end
      return $urandom_range(99) < 29;
   endfunction

   function automatic set_result_type apply_set_op(input logic [ACT_W-1:0] act,
                                                   input logic [VAL_W-1:0] val);
      set_result_type r;
      bit             hit;
      int             hit_slot;
      hit      = 1'b0;
      hit_slot = 0;
      for (int i = 0; i < held_count; i++) begin
         if (!hit && slots[i] == val) begin
            hit      = 1'b1;
            hit_slot = i;
         end
      end
      if (act == ACT_INSERT) begin
         if (hit) begin
            r.status = ST_PRESENT;
         end else if (held_count >= CAPACITY) begin
            r.status = ST_FULL;
            hit_slot = 0;
         end else begin
            hit_slot          = held_count;
            slots[held_count] = val;
            held_count++;
            r.status = ST_INSERTED;
         end
      end else if (act == ACT_DELETE) begin
         if (hit) begin
            // later entries close the gap, order kept
            for (int i = hit_slot; i + 1 < held_count; i++) begin
               slots[i] = slots[i + 1];
            end
            held_count--;
            r.status = ST_REMOVED;
         end else begin
            r.status = ST_ABSENT;
            hit_slot = 0;
         end
      end else begin
         // the spare code behaves as a lookup
         if (hit) begin
            r.status = ST_FOUND;
         end else begin
            r.status = ST_ABSENT;
            hit_slot = 0;
         end
      end
      r.position = POS_W'(hit_slot);
      r.count    = CNT_OUT_W'(held_count);
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0d] mismatch: %s", cycle_count, msg);
   endtask

   task automatic queue_op(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] val);
      set_op_type op;
      op.drain  = 1'b0;
      op.action = act;
      op.value  = val;
      pending_ops.push_back(op);
      n_total++;
   endtask

   task automatic queue_drain();
      set_op_type op;
      op.drain  = 1'b1;
      op.action = ACT_LOOKUP;
      op.value  = '0;
      pending_ops.push_back(op);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // driver: holds the payload until the transfer, predicts at the transfer
   always @(posedge clock) begin : drive_proc
      bit             accepted;
      set_op_type     op;
      set_result_type predicted;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         accepted = req_valid && !req_stall;
         if (accepted) begin
            predicted = apply_set_op(req_action, req_value);
            expected_results.push_back(predicted);
            n_accepted <= n_accepted + 1;
         end
         if (!req_valid || accepted) begin
            if (pending_ops.size() != 0 && pending_ops[0].drain) begin
               // hold off until every outstanding result is back
               if (!accepted && n_checked == n_accepted) begin
                  void'(pending_ops.pop_front());
               end
               req_valid <= 1'b0;
            end else if (pending_ops.size() != 0 && !roll_idle()) begin
               op = pending_ops.pop_front();
               req_valid  <= 1'b1;
               req_action <= op.action;
               req_value  <= op.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compares each result transfer with the oldest prediction
   always @(posedge clock) begin : check_proc
      set_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result status %0d pos %0d count %0d",
                                         rsp_status, rsp_position, rsp_count));
            end else begin
               want = expected_results.pop_front();
               n_checked <= n_checked + 1;
               if (rsp_status !== want.status) begin
                  report_mismatch($sformatf("result %0d status %0d, want %0d",
                                            n_checked, rsp_status, want.status));
               end
               if (rsp_position !== want.position) begin
                  report_mismatch($sformatf("result %0d position %0d, want %0d",
                                            n_checked, rsp_position, want.position));
               end
               if (rsp_count !== want.count) begin
                  report_mismatch($sformatf("result %0d count %0d, want %0d",
                                            n_checked, rsp_count, want.count));
               end
            end
         end
         rsp_stall <= roll_idle();
      end
   end

   initial begin : stimulus_proc
      mix_type          mix;
      int               roll;
      logic [ACT_W-1:0] act;
      logic [VAL_W-1:0] val;

      value_pool[0] = VAL_MIN;
      value_pool[1] = VAL_MAX;
      value_pool[2] = '0;
      value_pool[3] = '1;
      for (int i = 4; i < POOL_SIZE; i++) begin
         value_pool[i] = $urandom;
      end

      // directed: empty table, extremes, duplicates, spare code, shifting deletes
      queue_op(ACT_LOOKUP, 32'd5);
      queue_op(ACT_DELETE, 32'd5);
      queue_op(ACT_SPARE, 32'd5);
      queue_op(ACT_INSERT, VAL_MIN);
      queue_op(ACT_INSERT, VAL_MAX);
      queue_op(ACT_INSERT, 32'h0000_0000);
      queue_op(ACT_INSERT, 32'hffff_ffff);
      queue_op(ACT_INSERT, 32'h0000_0001);
      queue_op(ACT_INSERT, 32'h5555_5555);
      queue_op(ACT_INSERT, 32'haaaa_aaaa);
      queue_op(ACT_INSERT, VAL_MAX);
      queue_op(ACT_LOOKUP, 32'h0000_0000);
      queue_op(ACT_SPARE, 32'hffff_ffff);
      queue_op(ACT_LOOKUP, 32'h7fff_fffe);
      queue_op(ACT_DELETE, 32'h0000_0000);
      queue_op(ACT_LOOKUP, 32'hffff_ffff);
      queue_op(ACT_DELETE, VAL_MIN);
      queue_op(ACT_DELETE, 32'haaaa_aaaa);
      queue_op(ACT_DELETE, 32'h0000_0000);
      queue_op(ACT_INSERT, 32'h0000_0000);
      queue_op(ACT_LOOKUP, 32'h0000_0001);
      queue_drain();

      // random: phases that grow the set to full, churn it, and drain it
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case ((n / PHASE_ITEMS) % 4)
            0:       mix = MIX_GROW;
            2:       mix = MIX_SHRINK;
            default: mix = MIX_EVEN;
         endcase
         roll = $urandom_range(99);
         if (roll < 5) begin
            act = ACT_SPARE;
         end else if (mix == MIX_GROW) begin
            act = (roll < 80) ? ACT_INSERT : (roll < 90) ? ACT_DELETE : ACT_LOOKUP;
         end else if (mix == MIX_SHRINK) begin
            act = (roll < 15) ? ACT_INSERT : (roll < 80) ? ACT_DELETE : ACT_LOOKUP;
         end else begin
            act = (roll < 40) ? ACT_INSERT : (roll < 70) ? ACT_DELETE : ACT_LOOKUP;
         end
         if ($urandom_range(99) < 88) begin
            val = value_pool[$urandom_range(POOL_SIZE - 1)];
         end else begin
            val = $urandom;
         end
         queue_op(act, val);
         if (n % DRAIN_EVERY == DRAIN_EVERY - 1) begin
            queue_drain();
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (!(n_accepted == n_total && n_checked == n_total)) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
      end

      if (mismatch_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
